/* src/hslc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB color unit package
// Shared constants, codes and control types of the color conversion pipeline.
// ----------------------------------------------------------------------------
package hslc_pkg;

  // Default fractional bits of hue, saturation and lightness.
  localparam int unsigned FracBitsDefault = 12;
  // Integer bits of the hue in turns.
  localparam int unsigned HueIntBits = 6;
  // Width of one color channel.
  localparam int unsigned ChanW = 8;
  // Number of color channels.
  localparam int unsigned NumChan = 3;
  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSaturation = 1'b0,
    CfgLightness  = 1'b1
  } cfg_reg_e;

  // Hue offset applied for one channel.
  typedef enum logic [1:0] {
    OffPlus  = 2'd0,
    OffZero  = 2'd1,
    OffMinus = 2'd2
  } hue_off_e;

  // Stage control handed to each channel lane.
  typedef struct packed {
    logic load_mul;
    logic load_out;
    logic grey;
  } hslc_lane_ctl_t;

endpackage

/* src/hslc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB color unit interfaces
// Valid/ready channels for configuration writes, hues and RGB results.
// ----------------------------------------------------------------------------
interface hslc_cfg_if import hslc_pkg::*; #(
  parameter int unsigned DataW = FracBitsDefault + 1
) ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface hslc_hue_if import hslc_pkg::*; #(
  parameter int unsigned HueW = FracBitsDefault + HueIntBits
) ();
  logic            valid;
  logic            ready;
  logic [HueW-1:0] hue_turns;

  modport source (output valid, output hue_turns, input ready);
  modport sink   (input valid, input hue_turns, output ready);
endinterface

interface hslc_rgb_if import hslc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* src/hslc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB front stage
// Clamps the settings, removes whole turns from the hue and applies the
// lightness penalty for each removed turn.
// ----------------------------------------------------------------------------
module hslc_front import hslc_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [FracBits+HueIntBits-1:0] hue_i,
  input  logic [FracBits:0]              sat_i,
  input  logic [FracBits:0]              lit_i,
  output logic [FracBits:0]              hue_o,
  output logic [FracBits:0]              sat_o,
  output logic [FracBits:0]              lit_o,
  output logic                           grey_o
);

  localparam int unsigned HueW    = FracBits + HueIntBits;
  localparam int unsigned QW      = FracBits + 1;
  localparam int unsigned PenW    = FracBits + HueIntBits;
  localparam int unsigned OneInt  = 1 << FracBits;
  localparam int unsigned PenInt  = (2 * OneInt + 5) / 10;
  localparam logic [QW-1:0]   One     = QW'(OneInt);
  localparam logic [PenW-1:0] Penalty = PenW'(PenInt);

  logic [HueW-1:0]       hue_m1;
  logic                  hue_zero;
  logic [HueIntBits-1:0] turns;
  logic [QW-1:0]         hue_red;
  logic [PenW-1:0]       pen;
  logic [QW-1:0]         sat_c;
  logic [QW-1:0]         lit_c;
  logic [QW-1:0]         lit_p;

  logic [QW-1:0] hue_q, sat_q, lit_q;
  logic          grey_q;

  always_comb begin
    hue_zero = (hue_i == '0);
    hue_m1   = hue_i - HueW'(1);
    // A whole hue of k turns keeps 1.0 after k-1 removals.
    turns    = hue_zero ? '0 : hue_m1[HueW-1:FracBits];
    hue_red  = hue_zero ? '0 : ({1'b0, hue_m1[FracBits-1:0]} + QW'(1));
    sat_c    = (sat_i > One) ? One : sat_i;
    lit_c    = (lit_i > One) ? One : lit_i;
    pen      = PenW'(turns) * Penalty;
    // Lightness at or below zero gives black on every path.
    lit_p    = (PenW'(lit_c) > pen) ? (lit_c - pen[QW-1:0]) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q  <= hue_red;
      sat_q  <= sat_c;
      lit_q  <= lit_p;
      grey_q <= (sat_c == '0);
    end
  end

  assign hue_o  = hue_q;
  assign sat_o  = sat_q;
  assign lit_o  = lit_q;
  assign grey_o = grey_q;

endmodule

/* src/hslc_weight.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB segment weight
// Offsets and wraps the hue of one channel and picks the weight of the
// difference term of the piecewise-linear curve.
// ----------------------------------------------------------------------------
module hslc_weight import hslc_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault,
  parameter hue_off_e    Offset   = OffZero
) (
  input  logic [FracBits:0]   hue_i,
  output logic [FracBits+1:0] weight_o
);

  localparam int unsigned QW     = FracBits + 1;
  localparam int unsigned SW     = FracBits + 3;
  localparam int unsigned MW     = FracBits + 4;
  localparam int unsigned TW     = FracBits + 2;
  localparam int unsigned OneInt = 1 << FracBits;
  localparam logic signed [SW-1:0] OneS   = SW'(OneInt);
  localparam logic signed [SW-1:0] ThirdS = SW'(OneInt / 3);
  localparam logic [MW-1:0] OneM      = MW'(OneInt);
  localparam logic [MW-1:0] TwoOneM   = MW'(2 * OneInt);
  localparam logic [QW-1:0] TwoThirds = QW'((2 * OneInt + 1) / 3);

  logic signed [SW-1:0] off;
  logic signed [SW-1:0] hs;
  logic [QW-1:0]        h;
  logic [MW-1:0]        h2, h3, h6;
  logic [QW-1:0]        span;
  logic [MW-1:0]        span6;

  always_comb begin
    unique case (Offset)
      OffPlus:  off = ThirdS;
      OffMinus: off = -ThirdS;
      default:  off = '0;
    endcase
    hs = $signed({2'b00, hue_i}) + off;
    if (hs < 0) begin
      hs = hs + OneS;
    end else if (hs > OneS) begin
      hs = hs - OneS;
    end
    h     = hs[QW-1:0];
    h2    = {2'b00, h, 1'b0};
    h3    = h2 + MW'(h);
    h6    = {h3[MW-2:0], 1'b0};
    span  = TwoThirds - h;
    span6 = {2'b00, span, 1'b0} + {1'b0, span, 2'b00};
    priority if (h6 < OneM) begin
      weight_o = h6[TW-1:0];
    end else if (h2 < OneM) begin
      weight_o = TW'(OneInt);
    end else if (h3 < TwoOneM) begin
      weight_o = span6[TW-1:0];
    end else begin
      weight_o = '0;
    end
  end

endmodule

/* src/hslc_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB channel lane
// Multiplies the difference term by the segment weight, then scales the
// channel to a byte with truncation and clamping, or passes the grey byte.
// ----------------------------------------------------------------------------
module hslc_lane import hslc_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                       clk_i,
  input  hslc_lane_ctl_t             ctl_i,
  input  logic [2*FracBits-1:0]      half_diff_i,
  input  logic [FracBits+1:0]        weight_i,
  input  logic [2*FracBits:0]        low_i,
  input  logic [ChanW-1:0]           grey_i,
  output logic [ChanW-1:0]           chan_o
);

  localparam int unsigned XW = 2 * FracBits;
  localparam int unsigned TW = FracBits + 2;
  localparam int unsigned PW = XW + TW;
  localparam int unsigned UW = PW - FracBits + 1;
  localparam int unsigned SW = UW + ChanW;
  localparam int unsigned RW = SW - XW;

  logic [PW-1:0]    prod_q;
  logic [UW-1:0]    sum;
  logic [SW-1:0]    scaled;
  logic [RW-1:0]    res;
  logic [ChanW-1:0] byte_d;
  logic [ChanW-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_mul) begin
      prod_q <= PW'(half_diff_i) * PW'(weight_i);
    end
  end

  always_comb begin
    // The difference term is twice the half difference, so drop one bit less.
    sum    = UW'(low_i) + prod_q[PW-1:FracBits-1];
    scaled = {sum, ChanW'(0)} - SW'(sum);
    res    = scaled[SW-1:XW];
    if (ctl_i.grey) begin
      byte_d = grey_i;
    end else if (res > RW'({ChanW{1'b1}})) begin
      byte_d = '1;
    end else begin
      byte_d = res[ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      byte_q <= byte_d;
    end
  end

  assign chan_o = byte_q;

endmodule

/* src/hsl_to_rgb_color_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB color unit
// Converts a stream of hues to RGB bytes at fixed saturation and lightness.
// Each hue transaction carries an unsigned turn count with FracBits fraction
// bits; whole turns above one are removed and each one lowers the lightness
// by one fifth. Saturation and lightness are written through the
// configuration channel (index 0 saturation, index 1 lightness, values above
// 1.0 act as 1.0) and must only change while no transaction is in flight.
// The unit is a four-stage pipeline: turn removal and penalty, helper product
// and segment weights, one weight multiplier per channel, and byte scaling
// into the output register. It takes one hue every clock cycle while the
// output is not stalled; a result is offered on the output from the fourth
// stage register. Each stage holds its transaction only while the next
// stage is full and cannot move on, so bubbles close up under backpressure
// and nothing is dropped.
// ----------------------------------------------------------------------------
module hsl_to_rgb_color_unit import hslc_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hslc_cfg_if.sink   cfg_i,
  hslc_hue_if.sink   hue_i,
  hslc_rgb_if.source rgb_o
);

  localparam int unsigned QW        = FracBits + 1;
  localparam int unsigned XW        = 2 * FracBits;
  localparam int unsigned VW        = 2 * FracBits + 1;
  localparam int unsigned TW        = FracBits + 2;
  localparam int unsigned GW        = QW + ChanW;
  localparam int unsigned NumStages = 4;
  localparam int unsigned OneInt    = 1 << FracBits;
  localparam logic [QW-1:0] One  = QW'(OneInt);
  localparam logic [QW-1:0] Half = QW'(OneInt / 2);

  // Configuration registers. Writes are always taken.
  logic [QW-1:0] sat_q, lit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= One;
      lit_q <= Half;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CfgSaturation: sat_q <= cfg_i.data;
        CfgLightness:  lit_q <= cfg_i.data;
      endcase
    end
  end

  // Valid bits of the pipeline. A stage loads when it is empty or when the
  // stage after it moves on.
  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   stage_rdy;
  logic [NumStages-1:0] vld_in;

  always_comb begin
    stage_rdy[NumStages] = rgb_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      stage_rdy[k] = !vld_q[k] || stage_rdy[k+1];
    end
    vld_in = {vld_q[NumStages-2:0], hue_i.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (stage_rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign hue_i.ready = stage_rdy[0];
  assign rgb_o.valid = vld_q[NumStages-1];

  // Stage 1: reduced hue, clamped settings and lightness after the penalty.
  logic [QW-1:0] hue1, sat1, lit1;
  logic          grey1;

  hslc_front #(
    .FracBits(FracBits)
  ) u_front (
    .clk_i (clk_i),
    .en_i  (stage_rdy[0]),
    .hue_i (hue_i.hue_turns),
    .sat_i (sat_q),
    .lit_i (lit_q),
    .hue_o (hue1),
    .sat_o (sat1),
    .lit_o (lit1),
    .grey_o(grey1)
  );

  // Stage 2: the half difference of the two helper values, which is the
  // saturation times the distance of lightness to the nearer of 0 and 1.
  // The segment weights of the three channels are found in parallel.
  logic [QW-1:0]   near;
  logic [XW:0]     half_diff_full;
  logic [XW-1:0]   half_diff2_q;
  logic [QW-1:0]   lit2_q;
  logic            grey2_q;
  logic [TW-1:0]   weight[NumChan];
  logic [TW-1:0]   weight2_q[NumChan];

  always_comb begin
    near           = (lit1 < Half) ? lit1 : (One - lit1);
    half_diff_full = (XW+1)'(sat1) * (XW+1)'(near);
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_weight
    hslc_weight #(
      .FracBits(FracBits),
      .Offset  (hue_off_e'(2'(c)))
    ) u_weight (
      .hue_i   (hue1),
      .weight_o(weight[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[1]) begin
      half_diff2_q <= half_diff_full[XW-1:0];
      lit2_q       <= lit1;
      grey2_q      <= grey1;
      for (int c = 0; c < NumChan; c++) begin
        weight2_q[c] <= weight[c];
      end
    end
  end

  // Stage 3: the lower helper value and the grey byte; the lanes multiply.
  // The grey byte never exceeds 255 because the lightness is at most 1.0.
  logic [VW-1:0]    low3_q;
  logic [ChanW-1:0] grey_byte3_q;
  logic             grey3_q;
  logic [GW-1:0]    grey_scaled;

  assign grey_scaled = {lit2_q, ChanW'(0)} - GW'(lit2_q);

  always_ff @(posedge clk_i) begin
    if (stage_rdy[2]) begin
      low3_q       <= {lit2_q, FracBits'(0)} - VW'(half_diff2_q);
      grey_byte3_q <= grey_scaled[FracBits+ChanW-1:FracBits];
      grey3_q      <= grey2_q;
    end
  end

  // Stage 4 lives in the lanes: byte scaling into the output registers.
  hslc_lane_ctl_t   lane_ctl;
  logic [ChanW-1:0] chan[NumChan];

  always_comb begin
    lane_ctl.load_mul = stage_rdy[2];
    lane_ctl.load_out = stage_rdy[3];
    lane_ctl.grey     = grey3_q;
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    hslc_lane #(
      .FracBits(FracBits)
    ) u_lane (
      .clk_i      (clk_i),
      .ctl_i      (lane_ctl),
      .half_diff_i(half_diff2_q),
      .weight_i   (weight2_q[c]),
      .low_i      (low3_q),
      .grey_i     (grey_byte3_q),
      .chan_o     (chan[c])
    );
  end

  assign rgb_o.red   = chan[0];
  assign rgb_o.green = chan[1];
  assign rgb_o.blue  = chan[2];

endmodule

/* src/hslc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB color unit checker
// Port-level properties of the color unit, bound to the top level.
// ----------------------------------------------------------------------------
module hslc_checker import hslc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [NumChan*ChanW-1:0] out_data_i,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A result that is not taken keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // Configuration writes are never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

  // When the output stage can move, the pipeline takes a new hue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i || !out_valid_i |-> in_ready_i)
    else $error("input stalled with room in the pipeline");

endmodule

bind hsl_to_rgb_color_unit hslc_checker u_hslc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (hue_i.ready),
  .out_valid_i(rgb_o.valid),
  .out_ready_i(rgb_o.ready),
  .out_data_i ({rgb_o.red, rgb_o.green, rgb_o.blue}),
  .cfg_valid_i(cfg_i.valid),
  .cfg_ready_i(cfg_i.ready)
);

/* tb/tb_hsl_to_rgb_color_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB color unit testbench
// Streams hues through the unit under several saturation and lightness
// settings and checks every RGB transaction against a cycle-free predictor
// of the conversion. Directed hues cover turn boundaries, wrap-around,
// grey output and out-of-range register values; the random part mixes
// small hues with full-range ones while both sides idle in bursts.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_color_unit;
  import hslc_pkg::*;

  localparam int unsigned FracBits = FracBitsDefault;
  localparam int unsigned HueW     = FracBits + HueIntBits;
  localparam int unsigned LevelW   = FracBits + 1;

  // Fixed-point constants of the conversion, all in units of 2^-FracBits.
  localparam longint One       = longint'(1) << FracBits;
  localparam longint Half      = One / 2;
  localparam longint Penalty   = (One * 2 + 5) / 10;
  localparam longint Third     = One / 3;
  localparam longint TwoThirds = (2 * One + 1) / 3;

  // Settling time before a register write or at the end of the run.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReported  = 10;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // A pending color together with the hue that produced it, for reporting.
  typedef struct packed {
    logic [HueW-1:0] hue;
    rgb_t            rgb;
  } pending_color_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hslc_cfg_if #(.DataW(LevelW)) cfg_if ();
  hslc_hue_if #(.HueW(HueW))    hue_if ();
  hslc_rgb_if                   rgb_if ();

  hsl_to_rgb_color_unit #(
    .FracBits(FracBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .hue_i (hue_if),
    .rgb_o (rgb_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copies of the two configuration registers, updated when a write
  // transaction is accepted.
  logic [LevelW-1:0] saturation_q;
  logic [LevelW-1:0] lightness_q;

  pending_color_t pending_colors[$];

  bit idle_en;
  int unsigned hues_sent;
  int unsigned colors_checked;
  int unsigned settings_used;
  int unsigned fail_cnt;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Level of one channel in Q3.F from the two HSL helper values (Q2.F) and
  // the hue of that channel after its offset. The hue is wrapped into one
  // turn first, then the usual four segments of the HSL curve apply.
  function automatic longint channel_level(longint v1, longint v2, longint hue);
    longint d;
    longint h;
    d = v2 - v1;
    h = hue;
    if (h < 0) h += One;
    if (h > One) h -= One;
    if (6 * h < One) return v1 * One + d * 6 * h;
    if (2 * h < One) return v2 * One;
    if (3 * h < 2 * One) return v1 * One + d * (TwoThirds - h) * 6;
    return v1 * One;
  endfunction

  // A channel level becomes a byte by dropping to Q2.F, scaling by 255 and
  // flooring. Anything at or below zero is black, anything past full scale
  // clamps to 255.
  function automatic logic [ChanW-1:0] level_to_byte(longint level);
    longint scaled;
    if (level <= 0) return '0;
    scaled = ((level >>> FracBits) * 255) >>> (2 * FracBits);
    if (scaled > 255) return 8'hFF;
    return scaled[ChanW-1:0];
  endfunction

  function automatic rgb_t predict_rgb(logic [HueW-1:0] hue_turns);
    longint h;
    longint s;
    longint l;
    longint turns;
    longint v1;
    longint v2;
    longint grey;
    rgb_t   color;
    h = longint'(hue_turns);
    s = longint'(saturation_q);
    l = longint'(lightness_q);
    // Register values above one act as one.
    if (s > One) s = One;
    if (l > One) l = One;
    // Remove whole turns above one. An exact multiple of a turn stops at 1.0,
    // and every removed turn darkens the color by one fifth.
    turns = (h == 0) ? 0 : ((h - 1) >>> FracBits);
    h -= turns * One;
    l -= turns * Penalty;
    if (s == 0) begin
      grey = 0;
      if (l > 0) begin
        grey = (l * 255) >>> FracBits;
        if (grey > 255) grey = 255;
      end
      color.red   = grey[ChanW-1:0];
      color.green = grey[ChanW-1:0];
      color.blue  = grey[ChanW-1:0];
      return color;
    end
    // The lightness may be negative here; it is used as it stands.
    if (l < Half) v2 = l * (One + s);
    else v2 = l * One + s * One - s * l;
    v1 = 2 * l * One - v2;
    color.red   = level_to_byte(channel_level(v1, v2, h + Third));
    color.green = level_to_byte(channel_level(v1, v2, h));
    color.blue  = level_to_byte(channel_level(v1, v2, h - Third));
    return color;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random backpressure and the checker
  // --------------------------------------------------------------------------

  // The sink stalls in randomly started bursts while idling is enabled.
  int unsigned stall_left;
  always @(posedge clk_i) begin
    logic ready_next;
    if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    rgb_if.ready <= ready_next;
  end

  // Every accepted RGB transaction is matched against the oldest pending
  // color. Inputs are driven with nonblocking assignments, so the values seen
  // here are the ones that were present at the edge.
  always @(posedge clk_i) begin
    pending_color_t want;
    if (rst_ni && rgb_if.valid && rgb_if.ready) begin
      if (pending_colors.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReported) begin
          $display("[%0t] unexpected color r=%0d g=%0d b=%0d", $realtime,
                   rgb_if.red, rgb_if.green, rgb_if.blue);
        end
      end else begin
        want = pending_colors.pop_front();
        colors_checked++;
        if (rgb_if.red !== want.rgb.red || rgb_if.green !== want.rgb.green ||
            rgb_if.blue !== want.rgb.blue) begin
          fail_cnt++;
          if (fail_cnt <= MaxReported) begin
            $display("[%0t] hue 0x%05h: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $realtime, want.hue, want.rgb.red, want.rgb.green, want.rgb.blue,
                     rgb_if.red, rgb_if.green, rgb_if.blue);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offers one hue and waits for its transaction. The valid line stays high
  // between back-to-back hues; an idle burst lowers it first.
  task automatic send_hue(input logic [HueW-1:0] hue);
    pending_color_t entry;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      hue_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    hue_if.valid     <= 1'b1;
    hue_if.hue_turns <= hue;
    do @(posedge clk_i); while (!hue_if.ready);
    entry.hue = hue;
    entry.rgb = predict_rgb(hue);
    pending_colors = {pending_colors, entry};
    hues_sent++;
  endtask

  // Stops the hue stream and waits until every pending color has come back,
  // then lets the pipeline settle. Register writes only happen after this.
  task automatic wait_drained();
    int unsigned waited;
    hue_if.valid <= 1'b0;
    waited = 0;
    while (pending_colors.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_colors.size() != 0) begin
      fail_cnt += pending_colors.size();
      $display("[%0t] %0d colors never arrived", $realtime, pending_colors.size());
      pending_colors.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Offers one register write and waits for its transaction. The valid line
  // is lowered by the caller once all writes of a setting are done.
  task automatic write_reg(input cfg_reg_e index, input logic [LevelW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (index == CfgSaturation) saturation_q = value;
    else lightness_q = value;
  endtask

  task automatic apply_setting(input logic [LevelW-1:0] sat, input logic [LevelW-1:0] light);
    wait_drained();
    write_reg(CfgSaturation, sat);
    write_reg(CfgLightness, light);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Most hues stay within a few turns so the colors are not simply black;
  // the rest hit exact turn multiples or spread over the whole field.
  function automatic logic [HueW-1:0] draw_hue();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return HueW'($urandom_range(0, 2 * One));
      4, 5, 6:    return HueW'($urandom_range(0, 6 * One));
      7:          return HueW'($urandom_range(0, 63) * One);
      default:    return HueW'($urandom_range(0, (1 << HueW) - 1));
    endcase
  endfunction

  // Register values: mostly in range, with extremes and raw 13-bit values.
  function automatic logic [LevelW-1:0] draw_level();
    logic [LevelW-1:0] edges[7];
    edges = '{0, 1, Half - 1, Half, One - 1, One, (1 << LevelW) - 1};
    case ($urandom_range(0, 5))
      0:       return edges[$urandom_range(0, 6)];
      1:       return LevelW'($urandom_range(0, (1 << LevelW) - 1));
      default: return LevelW'($urandom_range(0, One));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values (full saturation, half lightness): segment boundaries of the
  // HSL curve, the zero hue, exact whole turns, the step just past a turn and
  // the largest hue, where the penalty drives everything to black.
  task automatic test_reset_setting();
    logic [HueW-1:0] hues[15];
    hues = '{0, 1, One / 6 - 1, One / 6, Half - 1, Half, TwoThirds - 1, TwoThirds,
             One - 1, One, One + 1, 2 * One, 3 * One, Third, (1 << HueW) - 1};
    foreach (hues[i]) send_hue(hues[i]);
  endtask

  // Grey output with zero saturation, and register values above one which
  // must act as one.
  task automatic test_grey_and_overrange();
    apply_setting(0, One);
    send_hue(0);
    send_hue(One);
    send_hue(One + 1);
    send_hue((1 << HueW) - 1);
    apply_setting((1 << LevelW) - 1, (1 << LevelW) - 1);
    send_hue(100);
    send_hue(5 * One + 321);
    apply_setting(One, 0);
    send_hue(Third);
  endtask

  // Random hues under a run of settings; the first few settings pin at least one
  // extreme value, the rest are drawn. Both sides idle in bursts.
  task automatic test_random_settings();
    logic [LevelW-1:0] sat;
    logic [LevelW-1:0] light;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       begin sat = 0;  light = draw_level(); end
        1:       begin sat = One; light = One; end
        2:       begin sat = (1 << LevelW) - 1; light = 0; end
        3:       begin sat = 1; light = (1 << LevelW) - 1; end
        default: begin sat = draw_level(); light = draw_level(); end
      endcase
      apply_setting(sat, light);
      repeat (210) send_hue(draw_hue());
    end
  endtask

  // Back-to-back stream without any idling, at a drawn setting.
  task automatic test_streaming();
    apply_setting(draw_level(), draw_level());
    idle_en = 1'b0;
    repeat (350) send_hue(draw_hue());
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni           = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CfgSaturation;
    cfg_if.data      = '0;
    hue_if.valid     = 1'b0;
    hue_if.hue_turns = '0;
    rgb_if.ready     = 1'b0;
    stall_left       = 0;
    idle_en          = 1'b1;
    saturation_q     = LevelW'(One);
    lightness_q      = LevelW'(Half);
    settings_used    = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_setting();
    test_grey_and_overrange();
    test_random_settings();
    test_streaming();
    wait_drained();

    $display("Sent %0d hues under %0d register settings, including grey, zero lightness",
             hues_sent, settings_used);
    $display("and out-of-range levels; %0d colors were checked.", colors_checked);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake: the slowest legal run needs well under
  // a tenth of this.
  initial begin
    #5_000_000;
    $display("Run timed out with %0d colors pending", pending_colors.size());
    $display("FAIL");
    $finish;
  end

endmodule

/* hsl_to_rgb_color_unit.f */
src/hslc_pkg.sv
src/hslc_if.sv
src/hslc_front.sv
src/hslc_weight.sv
src/hslc_lane.sv
src/hsl_to_rgb_color_unit.sv
src/hslc_checker.sv
tb/tb_hsl_to_rgb_color_unit.sv
